[rtl/assert_macros.svh]
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sfd_pkg.sv]
package sfd_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'hBE;
  localparam logic [7:0] TAIL_BYTE = 8'hEB;
  localparam logic [7:0] CODE_SAMPLES = 8'h00;
  localparam logic [7:0] CODE_STATUS  = 8'h01;
  localparam logic [7:0] MIN_LEN      = 8'd7;

  localparam logic [3:0] PULSE_MAX  = 4'd8;
  localparam logic [2:0] LIGHT_MAX  = 3'd4;
  localparam logic [3:0] SNORE_MAX  = 4'd10;
  localparam logic [1:0] MOTION_MAX = 2'd2;

  localparam logic [12:0] BATT_SCALE = 13'd20;

  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_PULSE  = 3'd1;
  localparam logic [2:0] REG_LIGHT  = 3'd2;
  localparam logic [2:0] REG_SNORE  = 3'd3;
  localparam logic [2:0] REG_MOTION = 3'd4;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] data;
    logic       hdr;
    logic       tail;
  } entry_t;

  typedef struct packed {
    logic [15:0] enable;
    logic [3:0]  pulse;
    logic [2:0]  light;
    logic [3:0]  snore;
    logic [1:0]  motion;
  } cfg_t;

  typedef struct packed {
    logic               kind;
    logic [3:0]         channel;
    logic signed [23:0] sample_value;
    logic [3:0]         sample_tag;
    logic [6:0]         slot;
    logic               last;
    logic [12:0]        battery_mv;
    logic [7:0]         charging;
    logic signed [7:0]  temperature;
    logic [31:0]        uptime;
    logic [8:0]         capacity;
    logic [8:0]         residual;
  } res_t;

  typedef logic [3:0][7:0] bytes4_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_SCAN_RD, ST_SCAN_CHK, ST_LEN_RD, ST_LEN_CHK, ST_TAIL_RD, ST_TAIL_CHK,
    ST_CODE_RD, ST_CODE_CHK, ST_CH, ST_SMP_RD, ST_SMP_CAP, ST_SMP_EMIT,
    ST_STAT_RD, ST_STAT_CAP, ST_STAT_EMIT, ST_FINISH, ST_DROP
  } st_t;

  typedef enum logic [2:0] {K_FP, K_LIGHT, K_ANGLE, K_S16, K_GYRO} kind_e;

  function automatic kind_e chan_kind(logic [3:0] ch);
    kind_e k;
    case (ch)
      4'd0, 4'd1:              k = K_FP;
      4'd2, 4'd3, 4'd4:        k = K_LIGHT;
      4'd5, 4'd6, 4'd7:        k = K_ANGLE;
      4'd10, 4'd11, 4'd12:     k = K_GYRO;
      default:                 k = K_S16;
    endcase
    return k;
  endfunction

  function automatic logic [2:0] kind_size(kind_e k);
    logic [2:0] s;
    case (k)
      K_FP:    s = 3'd4;
      K_ANGLE: s = 3'd2;
      default: s = 3'd3;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] chan_reps(logic [3:0] ch, cfg_t c);
    logic [3:0] r;
    case (ch)
      4'd0, 4'd1:       r = (c.pulse > PULSE_MAX) ? PULSE_MAX : c.pulse;
      4'd2, 4'd3, 4'd4: r = (c.light > LIGHT_MAX) ? 4'(LIGHT_MAX) : 4'(c.light);
      4'd5, 4'd6, 4'd7: r = 4'd1;
      4'd8, 4'd9:       r = (c.snore > SNORE_MAX) ? SNORE_MAX : c.snore;
      default:          r = (c.motion > MOTION_MAX) ? 4'(MOTION_MAX) : 4'(c.motion);
    endcase
    return r;
  endfunction

  function automatic logic signed [23:0] sample_value(kind_e k, bytes4_t b);
    logic [23:0] v;
    case (k)
      K_FP:    v = {b[3], b[2], b[1]};
      K_LIGHT: v = {{6{b[2][7]}}, b[2], b[1], b[0][7:6]};
      K_ANGLE: v = {{12{b[1][7]}}, b[1], b[0][7:4]};
      K_GYRO:  v = {{8{b[1][7]}}, b[1], b[2]};
      default: v = {{8{b[2][7]}}, b[2], b[1]};
    endcase
    return $signed(v);
  endfunction

  function automatic logic [3:0] sample_tag(kind_e k, bytes4_t b);
    logic [3:0] t;
    case (k)
      K_LIGHT: t = {2'b00, b[0][1:0]};
      K_ANGLE: t = 4'd0;
      default: t = b[0][3:0];
    endcase
    return t;
  endfunction

endpackage

[rtl/sfd_ram.sv]
module sfd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sfd_front.sv]
module sfd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      rx_byte,
  output logic            q_valid,
  output sfd_pkg::entry_t q_entry,
  input  logic            q_pop
);
  import sfd_pkg::*;

  entry_t         q [QDEPTH];
  logic [QAW-1:0] wptr;
  logic [QAW-1:0] rptr;
  logic [QAW:0]   count;
  logic           push;
  entry_t         new_entry;

  assign in_stall = (count == (QAW+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_entry  = q[rptr];

  // tag header and tail bytes on the way in
  always_comb begin
    new_entry.data = rx_byte;
    new_entry.hdr  = (rx_byte == HDR_BYTE);
    new_entry.tail = (rx_byte == TAIL_BYTE);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (q_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(q_pop);
    end
  end

endmodule

[rtl/sfd_back.sv]
`include "assert_macros.svh"

module sfd_back #(
  parameter int FRAME_BYTES = 256,
  parameter int SLOT_DEPTH  = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  sfd_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  sfd_pkg::entry_t q_entry,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output sfd_pkg::res_t   out_res
);
  import sfd_pkg::*;

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int FW = $clog2(FRAME_BYTES + 1);
  localparam logic [8:0] FB9 = 9'(FRAME_BYTES);

  st_t state, state_next;

  logic [AW-1:0] head, head_next;
  logic [FW-1:0] fill, fill_next;
  logic [7:0]    len, len_next;
  logic [4:0]    ch_cnt, ch_cnt_next;
  logic [3:0]    rep, rep_next;
  logic [7:0]    off, off_next;
  logic [3:0]    bidx, bidx_next;
  bytes4_t       smp_bytes, smp_bytes_next;
  logic [8:0][7:0] stat_bytes, stat_bytes_next;
  logic          pend_valid, pend_valid_next;
  res_t          pend, pend_next;
  logic [6:0]    slots [16];

  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  entry_t        rdata;

  logic          load_out;
  res_t          load_val;
  logic          slot_inc;

  logic [3:0]    ch;
  kind_e         cur_kind;
  logic [2:0]    cur_sz;
  logic [3:0]    cur_reps;
  logic [7:0]    plen;
  logic          out_free;
  logic          emit_ok;
  logic          ch_skip;
  logic          smp_short;
  logic          len_bad;
  res_t          smp_res;
  res_t          stat_res;

  function automatic logic [AW-1:0] wrap_addr(logic [AW-1:0] h, logic [8:0] o);
    logic [9:0] s;
    s = 10'(h) + 10'(o);
    if (s >= 10'(FRAME_BYTES)) begin
      s = s - 10'(FRAME_BYTES);
    end
    return s[AW-1:0];
  endfunction

  sfd_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(FRAME_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(q_entry),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign ch        = ch_cnt[3:0];
  assign cur_kind  = chan_kind(ch);
  assign cur_sz    = kind_size(cur_kind);
  assign cur_reps  = chan_reps(ch, cfg);
  assign plen      = len - MIN_LEN;
  assign out_free  = !out_valid || !out_stall;
  assign emit_ok   = !pend_valid || out_free;
  assign ch_skip   = !cfg.enable[4'd15 - ch] || (rep >= cur_reps);
  assign smp_short = (9'(off) + 9'(cur_sz)) > 9'(plen);
  assign len_bad   = (rdata.data < MIN_LEN) || (9'(rdata.data) > FB9);
  assign waddr     = wrap_addr(head, 9'(fill));

  always_comb begin
    smp_res              = '0;
    smp_res.channel      = ch;
    smp_res.sample_value = sample_value(cur_kind, smp_bytes);
    smp_res.sample_tag   = sample_tag(cur_kind, smp_bytes);
    smp_res.slot         = slots[ch];
  end

  always_comb begin
    stat_res             = '0;
    stat_res.kind        = 1'b1;
    stat_res.battery_mv  = 13'(13'(stat_bytes[0]) * BATT_SCALE);
    stat_res.charging    = stat_bytes[1];
    stat_res.temperature = $signed(stat_bytes[2]);
    stat_res.uptime      = {stat_bytes[6], stat_bytes[5], stat_bytes[4], stat_bytes[3]};
    stat_res.capacity    = {stat_bytes[7], 1'b0};
    stat_res.residual    = {stat_bytes[8], 1'b0};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (q_valid) state_next = ST_SCAN_RD;
      ST_SCAN_RD:   state_next = (fill == '0) ? ST_IDLE : ST_SCAN_CHK;
      ST_SCAN_CHK:  state_next = rdata.hdr ? ST_LEN_RD : ST_SCAN_RD;
      ST_LEN_RD:    state_next = (9'(fill) < 9'd2) ? ST_IDLE : ST_LEN_CHK;
      ST_LEN_CHK: begin
        if (!len_bad && (9'(fill) >= 9'(rdata.data))) begin
          state_next = ST_TAIL_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_TAIL_RD:   state_next = ST_TAIL_CHK;
      ST_TAIL_CHK:  state_next = rdata.tail ? ST_CODE_RD : ST_IDLE;
      ST_CODE_RD:   state_next = ST_CODE_CHK;
      ST_CODE_CHK: begin
        if (rdata.data == CODE_SAMPLES) begin
          state_next = ST_CH;
        end else if (rdata.data == CODE_STATUS) begin
          state_next = ST_STAT_RD;
        end else begin
          state_next = ST_DROP;
        end
      end
      ST_CH: begin
        if (ch_cnt[4]) begin
          state_next = ST_FINISH;
        end else if (ch_skip) begin
          state_next = ST_CH;
        end else if (smp_short) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_SMP_RD;
        end
      end
      ST_SMP_RD:    state_next = ST_SMP_CAP;
      ST_SMP_CAP:   state_next = (bidx == 4'(cur_sz - 3'd1)) ? ST_SMP_EMIT : ST_SMP_RD;
      ST_SMP_EMIT:  if (emit_ok) state_next = ST_CH;
      ST_STAT_RD:   state_next = ST_STAT_CAP;
      ST_STAT_CAP:  state_next = (bidx == 4'd8) ? ST_STAT_EMIT : ST_STAT_RD;
      ST_STAT_EMIT: if (emit_ok) state_next = ST_FINISH;
      ST_FINISH:    if (emit_ok) state_next = ST_DROP;
      ST_DROP:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    head_next       = head;
    fill_next       = fill;
    len_next        = len;
    ch_cnt_next     = ch_cnt;
    rep_next        = rep;
    off_next        = off;
    bidx_next       = bidx;
    smp_bytes_next  = smp_bytes;
    stat_bytes_next = stat_bytes;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    load_out        = 1'b0;
    load_val        = pend;
    slot_inc        = 1'b0;
    we              = 1'b0;
    q_pop           = 1'b0;
    raddr           = head;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (9'(fill) < FB9) begin
            we        = 1'b1;
            fill_next = fill + 1'b1;
          end
        end
      end
      ST_SCAN_RD: raddr = head;
      ST_SCAN_CHK: begin
        if (!rdata.hdr) begin
          head_next = wrap_addr(head, 9'd1);
          fill_next = fill - 1'b1;
        end
      end
      ST_LEN_RD: raddr = wrap_addr(head, 9'd1);
      ST_LEN_CHK: begin
        len_next = rdata.data;
        if (len_bad) begin
          head_next = wrap_addr(head, 9'd1);
          fill_next = fill - 1'b1;
        end
      end
      ST_TAIL_RD: raddr = wrap_addr(head, 9'(len) - 9'd1);
      ST_TAIL_CHK: begin
        if (!rdata.tail) begin
          head_next = wrap_addr(head, 9'd1);
          fill_next = fill - 1'b1;
        end
      end
      ST_CODE_RD: raddr = wrap_addr(head, 9'd3);
      ST_CODE_CHK: begin
        ch_cnt_next = '0;
        rep_next    = '0;
        off_next    = '0;
        bidx_next   = '0;
      end
      ST_CH: begin
        if (!ch_cnt[4] && ch_skip) begin
          ch_cnt_next = ch_cnt + 1'b1;
          rep_next    = '0;
        end else begin
          bidx_next = '0;
        end
      end
      ST_SMP_RD: raddr = wrap_addr(head, 9'd4 + 9'(off) + 9'(bidx));
      ST_SMP_CAP: begin
        smp_bytes_next[bidx[1:0]] = rdata.data;
        bidx_next                 = bidx + 1'b1;
      end
      ST_SMP_EMIT: begin
        if (emit_ok) begin
          load_out        = pend_valid;
          pend_valid_next = 1'b1;
          pend_next       = smp_res;
          slot_inc        = 1'b1;
          off_next        = off + 8'(cur_sz);
          rep_next        = rep + 1'b1;
        end
      end
      ST_STAT_RD: raddr = wrap_addr(head, 9'd4 + 9'(bidx));
      ST_STAT_CAP: begin
        // status bytes past the payload read as zero
        stat_bytes_next[bidx] = (8'(bidx) < plen) ? rdata.data : 8'd0;
        bidx_next             = bidx + 1'b1;
      end
      ST_STAT_EMIT: begin
        if (emit_ok) begin
          load_out        = pend_valid;
          pend_valid_next = 1'b1;
          pend_next       = stat_res;
        end
      end
      ST_FINISH: begin
        if (pend_valid && out_free) begin
          load_out        = 1'b1;
          load_val.last   = 1'b1;
          pend_valid_next = 1'b0;
        end
      end
      ST_DROP: begin
        head_next = wrap_addr(head, 9'(len));
        fill_next = fill - FW'(len);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      head       <= '0;
      fill       <= '0;
      ch_cnt     <= '0;
      rep        <= '0;
      off        <= '0;
      bidx       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      head       <= head_next;
      fill       <= fill_next;
      ch_cnt     <= ch_cnt_next;
      rep        <= rep_next;
      off        <= off_next;
      bidx       <= bidx_next;
      pend_valid <= pend_valid_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    len        <= len_next;
    smp_bytes  <= smp_bytes_next;
    stat_bytes <= stat_bytes_next;
    pend       <= pend_next;
    if (load_out) begin
      out_res <= load_val;
    end
  end

  // per-channel slot counters wrap at the slot depth
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        slots[i] <= '0;
      end
    end else if (slot_inc) begin
      if (slots[ch] == 7'(SLOT_DEPTH - 1)) begin
        slots[ch] <= '0;
      end else begin
        slots[ch] <= slots[ch] + 1'b1;
      end
    end
  end

  `ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, 9'(fill) <= FB9, "fill level beyond store depth")
  `ASSERT_IMPL(a_pop_idle, clk, rst, q_pop, (state == ST_IDLE) && !pend_valid, "byte taken mid-frame")
  `ASSERT_IMPL(a_drop_len, clk, rst, state == ST_DROP, (9'(fill) >= 9'(len)) && !pend_valid, "frame drop exceeds held bytes")
  `ASSERT_NEXT(a_last_flag, clk, rst, (state == ST_FINISH) && pend_valid && out_free, out_valid && out_res.last, "final result not marked last")

endmodule

[rtl/sensor_frame_deframer_decoder.sv]
// Sensor frame deframer and decoder.
// Input channel: one link byte per transfer on rx_byte (in_valid / in_stall).
// Output channel: one result per transfer (out_valid / out_stall): a decoded
// sample (kind 0) or a status report (kind 1); last marks the final result
// caused by one input byte. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must do so only while the block is idle,
// as the block does not enforce it. Bytes enter a four-entry queue and are
// then handled one at a time by the frame engine, which holds the frame in a
// store with one write port and one read port. The engine takes a new byte
// only when it is back in its idle state: it first scans for a header,
// dropping leading bytes that are not one, then checks the length and tail
// and, for a frame end, reads the payload bytes through the one read port of
// the frame store and emits the results; later bytes wait in the queue.
// Reset clears the queue, the fill level, the slot counters and the registers
// to their defaults; the store contents are not cleared and no sweep is run.
// While out_stall is high the finished result holds in the output register,
// one more waits in a pending stage and decoding pauses; input keeps flowing
// into the queue until it fills, then in_stall rises.
module sensor_frame_deframer_decoder #(
  parameter int FRAME_BYTES = 256,
  parameter int SLOT_DEPTH  = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               kind,
  output logic [3:0]         channel,
  output logic signed [23:0] sample_value,
  output logic [3:0]         sample_tag,
  output logic [6:0]         slot,
  output logic               last,
  output logic [12:0]        battery_mv,
  output logic [7:0]         charging,
  output logic signed [7:0]  temperature,
  output logic [31:0]        uptime,
  output logic [8:0]         capacity,
  output logic [8:0]         residual,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import sfd_pkg::*;

  cfg_t   cfg;
  logic   q_valid;
  entry_t q_entry;
  logic   q_pop;
  res_t   res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 16'd0;
      cfg.pulse  <= 4'd5;
      cfg.light  <= 3'd1;
      cfg.snore  <= 4'd10;
      cfg.motion <= 2'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: cfg.enable <= cfg_data;
        REG_PULSE:  cfg.pulse  <= cfg_data[3:0];
        REG_LIGHT:  cfg.light  <= cfg_data[2:0];
        REG_SNORE:  cfg.snore  <= cfg_data[3:0];
        REG_MOTION: cfg.motion <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  sfd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte (rx_byte),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  sfd_back #(
    .FRAME_BYTES(FRAME_BYTES),
    .SLOT_DEPTH (SLOT_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (res)
  );

  assign kind         = res.kind;
  assign channel      = res.channel;
  assign sample_value = res.sample_value;
  assign sample_tag   = res.sample_tag;
  assign slot         = res.slot;
  assign last         = res.last;
  assign battery_mv   = res.battery_mv;
  assign charging     = res.charging;
  assign temperature  = res.temperature;
  assign uptime       = res.uptime;
  assign capacity     = res.capacity;
  assign residual     = res.residual;

endmodule

[verif/sfd_result_checker.sv]
module sfd_result_checker
  import sfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         rx_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               kind,
  input  logic [3:0]         channel,
  input  logic signed [23:0] sample_value,
  input  logic [3:0]         sample_tag,
  input  logic [6:0]         slot,
  input  logic               last,
  input  logic [12:0]        battery_mv,
  input  logic [7:0]         charging,
  input  logic signed [7:0]  temperature,
  input  logic [31:0]        uptime,
  input  logic [8:0]         capacity,
  input  logic [8:0]         residual,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  link_buf [256];
  int          buf_fill;
  logic [6:0]  slot_ctr [16];
  logic [15:0] en_mask;
  logic [3:0]  n_pulse;
  logic [2:0]  n_light;
  logic [3:0]  n_snore;
  logic [1:0]  n_motion;
  res_t        frame_results [$];

  assign outstanding = frame_results.size();

  task automatic shift_out(input int k);
    for (int j = 0; j < buf_fill - k; j++) link_buf[j] = link_buf[j + k];
    buf_fill -= k;
  endtask

  function automatic int samples_per_frame(input int ch);
    int r;
    if (ch <= 1) r = (n_pulse > PULSE_MAX) ? PULSE_MAX : n_pulse;
    else if (ch <= 4) r = (n_light > LIGHT_MAX) ? LIGHT_MAX : n_light;
    else if (ch <= 7) r = 1;
    else if (ch <= 9) r = (n_snore > SNORE_MAX) ? SNORE_MAX : n_snore;
    else r = (n_motion > MOTION_MAX) ? MOTION_MAX : n_motion;
    return r;
  endfunction

  task automatic decode_sensor_frame(input int plen);
    int off, sz;
    logic [7:0] b0, b1, b2, b3;
    res_t s;
    bit stop;
    off = 0;
    stop = 0;
    for (int ch = 0; ch < 16 && !stop; ch++) begin
      if (!en_mask[15 - ch]) continue;
      sz = (ch <= 1) ? 4 : ((ch >= 5 && ch <= 7) ? 2 : 3);
      for (int r = 0; r < samples_per_frame(ch) && !stop; r++) begin
        if (off + sz > plen) begin
          stop = 1;
        end else begin
          b0 = link_buf[4 + off];
          b1 = link_buf[5 + off];
          b2 = (sz > 2) ? link_buf[6 + off] : 8'h00;
          b3 = (sz > 3) ? link_buf[7 + off] : 8'h00;
          s = '0;
          s.channel = 4'(ch);
          if (ch <= 1) begin
            s.sample_value = {b3, b2, b1};
            s.sample_tag = b0[3:0];
          end else if (ch <= 4) begin
            s.sample_value = {{6{b2[7]}}, b2, b1, b0[7:6]};
            s.sample_tag = {2'b00, b0[1:0]};
          end else if (ch <= 7) begin
            s.sample_value = {{12{b1[7]}}, b1, b0[7:4]};
          end else if (ch >= 10 && ch <= 12) begin
            s.sample_value = {{8{b1[7]}}, b1, b2};
            s.sample_tag = b0[3:0];
          end else begin
            s.sample_value = {{8{b2[7]}}, b2, b1};
            s.sample_tag = b0[3:0];
          end
          s.slot = slot_ctr[ch];
          slot_ctr[ch] = slot_ctr[ch] + 7'd1;
          frame_results.push_back(s);
          off += sz;
        end
      end
    end
  endtask

  task automatic decode_status_frame(input int plen);
    logic [7:0] p [9];
    res_t s;
    for (int k = 0; k < 9; k++) p[k] = (k < plen) ? link_buf[4 + k] : 8'h00;
    s = '0;
    s.kind = 1'b1;
    s.battery_mv = 13'(p[0]) * BATT_SCALE;
    s.charging = p[1];
    s.temperature = p[2];
    s.uptime = {p[6], p[5], p[4], p[3]};
    s.capacity = {p[7], 1'b0};
    s.residual = {p[8], 1'b0};
    frame_results.push_back(s);
  endtask

  task automatic take_link_byte(input logic [7:0] b);
    int i, flen, before_n;
    before_n = frame_results.size();
    if (buf_fill < 256) begin
      link_buf[buf_fill] = b;
      buf_fill++;
    end
    i = 0;
    while (i < buf_fill && link_buf[i] != HDR_BYTE) i++;
    shift_out(i);
    if (buf_fill >= 2) begin
      flen = link_buf[1];
      if (flen < MIN_LEN) begin
        shift_out(1);
      end else if (buf_fill >= flen) begin
        if (link_buf[flen - 1] != TAIL_BYTE) begin
          shift_out(1);
        end else begin
          if (link_buf[3] == CODE_SAMPLES) decode_sensor_frame(flen - 7);
          else if (link_buf[3] == CODE_STATUS) decode_status_frame(flen - 7);
          shift_out(flen);
        end
      end
    end
    if (frame_results.size() > before_n) frame_results[$].last = 1'b1;
  endtask

  task automatic check_field(input string fname, input longint e, input longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", fname, e, a);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      buf_fill = 0;
      for (int c = 0; c < 16; c++) slot_ctr[c] = '0;
      en_mask = 16'h0000;
      n_pulse = 4'd5;
      n_light = 3'd1;
      n_snore = 4'd10;
      n_motion = 2'd1;
      frame_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ENABLE: en_mask = cfg_data;
          REG_PULSE:  n_pulse = cfg_data[3:0];
          REG_LIGHT:  n_light = cfg_data[2:0];
          REG_SNORE:  n_snore = cfg_data[3:0];
          REG_MOTION: n_motion = cfg_data[1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (frame_results.size() == 0) begin
          $error("result transfer with nothing expected (kind %0d channel %0d)", kind, channel);
          fail_count++;
        end else begin
          e = frame_results.pop_front();
          check_field("kind", e.kind, kind);
          check_field("channel", e.channel, channel);
          check_field("sample_value", e.sample_value, sample_value);
          check_field("sample_tag", e.sample_tag, sample_tag);
          check_field("slot", e.slot, slot);
          check_field("last", e.last, last);
          check_field("battery_mv", e.battery_mv, battery_mv);
          check_field("charging", e.charging, charging);
          check_field("temperature", e.temperature, temperature);
          check_field("uptime", e.uptime, uptime);
          check_field("capacity", e.capacity, capacity);
          check_field("residual", e.residual, residual);
        end
      end
      if (in_valid && !in_stall) take_link_byte(rx_byte);
    end
  end

endmodule

[verif/sensor_frame_deframer_decoder_tb.sv]
module sensor_frame_deframer_decoder_tb;
  import sfd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [7:0]         rx_byte;
  logic               out_valid;
  logic               out_stall;
  logic               kind;
  logic [3:0]         channel;
  logic signed [23:0] sample_value;
  logic [3:0]         sample_tag;
  logic [6:0]         slot;
  logic               last;
  logic [12:0]        battery_mv;
  logic [7:0]         charging;
  logic signed [7:0]  temperature;
  logic [31:0]        uptime;
  logic [8:0]         capacity;
  logic [8:0]         residual;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 fail_count;
  int                 outstanding;

  int send_idle_pct;
  int stall_pct;
  int bytes_sent;
  int full_payload;

  sensor_frame_deframer_decoder dut (.*);
  sfd_result_checker chk (.*);

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(negedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  initial begin
    #4_000_000;
    $display("sensor_frame_deframer_decoder_tb failed");
    $finish;
  end

  task automatic put_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    bytes_sent++;
  endtask

  // header, length, spare, code, payload, two spare bytes, tail
  task automatic put_frame(input int flen, input logic [7:0] code, input bit good_tail);
    logic [7:0] t;
    put_byte(HDR_BYTE);
    put_byte(8'(flen));
    put_byte(8'($urandom));
    put_byte(code);
    for (int k = 0; k < flen - 5; k++) put_byte(8'($urandom));
    do t = 8'($urandom); while (t == TAIL_BYTE);
    put_byte(good_tail ? TAIL_BYTE : t);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    wait (outstanding == 0);
    @(negedge clk);
    repeat (1000) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] en, input logic [3:0] p, input logic [2:0] l,
                            input logic [3:0] s, input logic [1:0] m);
    int pc, lc, sc, mc;
    drain_results();
    write_reg(REG_ENABLE, en);
    write_reg(REG_PULSE, {12'h000, p});
    write_reg(REG_LIGHT, {13'h0000, l});
    write_reg(REG_SNORE, {12'h000, s});
    write_reg(REG_MOTION, {14'h0000, m});
    pc = (p > PULSE_MAX) ? PULSE_MAX : p;
    lc = (l > LIGHT_MAX) ? LIGHT_MAX : l;
    sc = (s > SNORE_MAX) ? SNORE_MAX : s;
    mc = (m > MOTION_MAX) ? MOTION_MAX : m;
    full_payload = 0;
    for (int ch = 0; ch < 16; ch++) begin
      if (!en[15 - ch]) continue;
      if (ch <= 1) full_payload += 4 * pc;
      else if (ch <= 4) full_payload += 3 * lc;
      else if (ch <= 7) full_payload += 2;
      else if (ch <= 9) full_payload += 3 * sc;
      else full_payload += 3 * mc;
    end
  endtask

  task automatic random_traffic(input int budget, input bit pause_midway);
    int stop_at, r, plen;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      if (pause_midway && bytes_sent > stop_at - budget / 2) begin
        pause_midway = 0;
        in_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
      end
      r = $urandom_range(99);
      if (r < 60) begin
        plen = ($urandom_range(4) != 0) ? full_payload : $urandom_range(full_payload + 4);
        if (plen > 248) plen = 248;
        put_frame(plen + 7, CODE_SAMPLES, 1'b1);
      end else if (r < 70) begin
        put_frame($urandom_range(7, 20), CODE_STATUS, 1'b1);
      end else if (r < 75) begin
        put_frame($urandom_range(7, 14), 8'($urandom_range(2, 255)), 1'b1);
      end else if (r < 85) begin
        put_frame($urandom_range(7, 24), 8'($urandom_range(1)), 1'b0);
      end else if (r < 92) begin
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
      end else begin
        put_byte(HDR_BYTE);
        put_byte(8'($urandom_range(MIN_LEN - 1)));
      end
    end
  endtask

  initial begin
    logic [15:0] en;
    rst = 1'b1;
    in_valid = 1'b0;
    rx_byte = 8'h00;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ENABLE;
    cfg_data = 16'h0000;
    send_idle_pct = 0;
    stall_pct = 0;
    bytes_sent = 0;
    full_payload = 0;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    // full status frame with extreme bytes, then a short one, then a bad length
    put_byte(HDR_BYTE);
    put_byte(8'd16);
    put_byte(8'hFF);
    put_byte(CODE_STATUS);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'h80);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h7F);
    put_byte(8'hFF);
    put_byte(8'hFF);
    put_byte(8'h00);
    put_byte(8'h00);
    put_byte(TAIL_BYTE);
    put_frame(9, CODE_STATUS, 1'b1);
    put_byte(HDR_BYTE);
    put_byte(8'd0);
    put_byte(8'h55);

    set_config(16'hFFFF, 4'd8, 3'd4, 4'd10, 2'd2);
    random_traffic(80, 1'b0);

    send_idle_pct = 82;
    set_config(16'hFFFF, 4'd15, 3'd7, 4'd15, 2'd3);
    random_traffic(80, 1'b1);

    send_idle_pct = 0;
    stall_pct = 82;
    en = 16'($urandom);
    set_config(en, 4'($urandom_range(3)), 3'($urandom_range(2)), 4'($urandom_range(3)),
               2'($urandom));
    random_traffic(80, 1'b0);

    send_idle_pct = 37;
    stall_pct = 37;
    set_config(16'h0000, 4'd0, 3'd0, 4'd0, 2'd0);
    random_traffic(40, 1'b0);

    send_idle_pct = 0;
    stall_pct = 0;
    set_config(16'hC000, 4'd8, 3'd1, 4'd1, 2'd1);
    random_traffic(120, 1'b0);

    send_idle_pct = 37;
    stall_pct = 37;
    set_config(~en, 4'($urandom_range(2)), 3'($urandom_range(1, 2)), 4'($urandom_range(2)),
               2'($urandom_range(1, 2)));
    random_traffic(80, 1'b0);

    drain_results();
    if (fail_count == 0) begin
      $display("sensor_frame_deframer_decoder_tb passed");
    end else begin
      $display("sensor_frame_deframer_decoder_tb failed");
    end
    $finish;
  end

endmodule
